// ----- design/mrtu_pkg.sv -----
`default_nettype none
package mrtu_pkg;

    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_CAL   = 3'd2;
    localparam logic [2:0] CMD_RX    = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_STAT = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [3:0] ST_CRC_ERR   = 4'd0;
    localparam logic [3:0] ST_READ_OK   = 4'd1;
    localparam logic [3:0] ST_READ_MIS  = 4'd2;
    localparam logic [3:0] ST_WRITE_OK  = 4'd3;
    localparam logic [3:0] ST_WRITE_MIS = 4'd4;
    localparam logic [3:0] ST_NOT_IMPL  = 4'd5;
    localparam logic [3:0] ST_CAL_OK    = 4'd6;
    localparam logic [3:0] ST_UNKNOWN   = 4'd7;
    localparam logic [3:0] ST_NO_REPLY  = 4'd8;
    localparam logic [3:0] ST_FRAME_ERR = 4'd9;

    localparam logic [2:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [2:0] CFG_FC_READ  = 3'd1;
    localparam logic [2:0] CFG_FC_WRITE = 3'd2;
    localparam logic [2:0] CFG_FC_MULTI = 3'd3;
    localparam logic [2:0] CFG_FC_CAL   = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [5:0]  MAX_DATA = 6'd59;

    typedef enum logic [3:0] {
        DP_NOP, DP_LATCH, DP_TX_INIT, DP_TX_BYTE, DP_RX_STORE, DP_TICK, DP_FEND,
        DP_STAT_PUSH, DP_RD_ISSUE, DP_RD_PUSH, DP_CMP_ISSUE, DP_CMP_CHECK
    } dp_op_t;

    typedef enum logic [1:0] {FE_STAT, FE_READ, FE_WRITE} fend_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_t;

    typedef struct packed {
        logic [2:0] command;
        logic       rx_last;
        logic       slot_free;
        logic       tx_last;
        logic       tick_hit;
        fend_t      fend;
        logic       rd_zero;
        logic       rd_last;
        logic       cmp_last;
    } dp_stat_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/mrtu_ctrl.sv -----
`default_nettype none
module mrtu_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire mrtu_pkg::dp_stat_t st,
    output mrtu_pkg::ctl_t         ctl
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_TX, S_FEND, S_STAT, S_RDSTAT,
        S_RDRQ, S_RDDAT, S_CMPRQ, S_CMPCHK
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl.op     = mrtu_pkg::DP_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.op     = mrtu_pkg::DP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_IDLE;
                case (st.command) inside
                    mrtu_pkg::CMD_READ, mrtu_pkg::CMD_WRITE, mrtu_pkg::CMD_CAL: begin
                        ctl.op     = mrtu_pkg::DP_TX_INIT;
                        state_next = S_TX;
                    end
                    mrtu_pkg::CMD_RX: begin
                        ctl.op = mrtu_pkg::DP_RX_STORE;
                        if (st.rx_last) state_next = S_FEND;
                    end
                    mrtu_pkg::CMD_TICK: begin
                        ctl.op = mrtu_pkg::DP_TICK;
                        if (st.tick_hit) state_next = S_STAT;
                    end
                    default: ;
                endcase
            end
            S_TX: begin
                if (st.slot_free) begin
                    ctl.op = mrtu_pkg::DP_TX_BYTE;
                    if (st.tx_last) state_next = S_IDLE;
                end
            end
            S_FEND: begin
                ctl.op = mrtu_pkg::DP_FEND;
                unique case (st.fend)
                    mrtu_pkg::FE_READ:  state_next = S_RDSTAT;
                    mrtu_pkg::FE_WRITE: state_next = S_CMPRQ;
                    default:            state_next = S_STAT;
                endcase
            end
            S_STAT: begin
                if (st.slot_free) begin
                    ctl.op     = mrtu_pkg::DP_STAT_PUSH;
                    state_next = S_IDLE;
                end
            end
            S_RDSTAT: begin
                if (st.slot_free) begin
                    ctl.op     = mrtu_pkg::DP_STAT_PUSH;
                    state_next = st.rd_zero ? S_IDLE : S_RDRQ;
                end
            end
            S_RDRQ: begin
                ctl.op     = mrtu_pkg::DP_RD_ISSUE;
                state_next = S_RDDAT;
            end
            S_RDDAT: begin
                if (st.slot_free) begin
                    ctl.op     = mrtu_pkg::DP_RD_PUSH;
                    state_next = st.rd_last ? S_IDLE : S_RDRQ;
                end
            end
            S_CMPRQ: begin
                ctl.op     = mrtu_pkg::DP_CMP_ISSUE;
                state_next = S_CMPCHK;
            end
            S_CMPCHK: begin
                ctl.op     = mrtu_pkg::DP_CMP_CHECK;
                state_next = st.cmp_last ? S_STAT : S_CMPRQ;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/mrtu_datapath.sv -----
`default_nettype none
module mrtu_datapath #(
    parameter int RESP_BYTES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mrtu_pkg::ctl_t     ctl,
    output mrtu_pkg::dp_stat_t      st,
    input  wire logic [87:0]        s_tdata,
    input  wire logic [2:0]         s_tuser,
    input  wire logic               s_tlast,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [15:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    localparam int LW = $clog2(RESP_BYTES + 1);
    localparam int AW = $clog2(RESP_BYTES);

    // configuration
    logic [15:0] ticks_reg;
    logic [7:0]  fc_read_reg, fc_write_reg, fc_multi_reg, fc_cal_reg;

    // latched input word
    logic [2:0]  cmd_reg;
    logic [7:0]  dev_reg, point_reg, rx_reg;
    logic [15:0] raddr_reg, cv_reg;
    logic [31:0] dens_reg;
    logic        rxl_reg;

    // request side
    logic [7:0]  req_reg [9];
    logic [3:0]  req_len_reg;
    logic [15:0] txcrc_reg;
    logic [5:0]  idx_reg;

    // response side
    logic [7:0]    mem [RESP_BYTES];
    logic [7:0]    rdata_reg;
    logic [LW-1:0] len_reg;
    logic          ovf_reg;
    logic [15:0]   lcrc_reg;
    logic [7:0]    prev1_reg, prev2_reg, r0_reg, r1_reg, r2_reg;
    logic [5:0]    cnt_reg;
    logic          mis_reg;

    logic [15:0] tcount_reg;
    logic        trun_reg;

    logic [3:0]  stat_code_reg;
    logic [7:0]  stat_data_reg;
    logic        stat_last_reg;

    logic        out_valid_reg, out_last_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_data_reg;
    logic [3:0]  out_status_reg;

    logic        slot_free;
    logic        push;
    logic [3:0]  idx4, nb;
    logic [7:0]  fc_sel, tx_byte;
    logic        tx_last;
    logic [15:0] tcount_inc;
    logic        tick_hit;
    logic [8:0]  len9, room9, cnt9, rd_addr9, cmp_addr9;
    logic        fe_short, fe_crc;
    mrtu_pkg::fend_t fe_kind;
    logic [3:0]  fe_code;
    logic [7:0]  fe_data;
    logic        cmp_mis;

    assign slot_free = !out_valid_reg || m_tready;
    assign push      = (ctl.op == mrtu_pkg::DP_TX_BYTE) || (ctl.op == mrtu_pkg::DP_STAT_PUSH) ||
                       (ctl.op == mrtu_pkg::DP_RD_PUSH);
    assign idx4      = idx_reg[3:0];
    assign nb        = (cmd_reg == mrtu_pkg::CMD_CAL) ? 4'd7 : 4'd6;
    assign tx_last   = (idx4 == nb + 4'd1);

    always_comb begin
        case (cmd_reg)
            mrtu_pkg::CMD_READ:  fc_sel = fc_read_reg;
            mrtu_pkg::CMD_WRITE: fc_sel = fc_write_reg;
            default:             fc_sel = fc_cal_reg;
        endcase
    end

    always_comb begin
        tx_byte = 8'h00;
        if (idx4 == nb) begin
            tx_byte = txcrc_reg[7:0];
        end else if (idx4 == nb + 4'd1) begin
            tx_byte = txcrc_reg[15:8];
        end else begin
            case (idx4)
                4'd0: tx_byte = dev_reg;
                4'd1: tx_byte = fc_sel;
                4'd2: tx_byte = (cmd_reg == mrtu_pkg::CMD_CAL) ? point_reg : raddr_reg[15:8];
                4'd3: tx_byte = (cmd_reg == mrtu_pkg::CMD_CAL) ? dens_reg[7:0] : raddr_reg[7:0];
                4'd4: tx_byte = (cmd_reg == mrtu_pkg::CMD_CAL) ? dens_reg[15:8] : cv_reg[15:8];
                4'd5: tx_byte = (cmd_reg == mrtu_pkg::CMD_CAL) ? dens_reg[23:16] : cv_reg[7:0];
                4'd6: tx_byte = dens_reg[31:24];
                default: tx_byte = 8'h00;
            endcase
        end
    end

    assign tcount_inc = tcount_reg + 16'd1;
    assign tick_hit   = trun_reg && (tcount_inc >= ticks_reg);

    // frame end classification
    assign len9  = 9'(len_reg);
    assign room9 = (len9 >= 9'd5) ? len9 - 9'd5 : 9'd0;
    always_comb begin
        cnt9 = {1'b0, r2_reg};
        if (cnt9 > room9) cnt9 = room9;
        if (cnt9 > 9'(mrtu_pkg::MAX_DATA)) cnt9 = 9'(mrtu_pkg::MAX_DATA);
    end

    assign fe_short = ovf_reg || (len9 < 9'd4);
    assign fe_crc   = ({prev1_reg, prev2_reg} != lcrc_reg);

    always_comb begin
        fe_kind = mrtu_pkg::FE_STAT;
        fe_data = 8'h00;
        fe_code = mrtu_pkg::ST_UNKNOWN;
        if (fe_short) begin
            fe_code = mrtu_pkg::ST_FRAME_ERR;
        end else if (fe_crc) begin
            fe_code = mrtu_pkg::ST_CRC_ERR;
        end else if (r1_reg == fc_read_reg) begin
            if (r0_reg != req_reg[0] || r1_reg != req_reg[1]) begin
                fe_code = mrtu_pkg::ST_READ_MIS;
            end else begin
                fe_code = mrtu_pkg::ST_READ_OK;
                fe_kind = mrtu_pkg::FE_READ;
            end
        end else if (r1_reg == fc_write_reg) begin
            fe_code = mrtu_pkg::ST_WRITE_MIS;
            if (len9 == 9'(req_len_reg)) fe_kind = mrtu_pkg::FE_WRITE;
        end else if (r1_reg == fc_multi_reg) begin
            fe_code = mrtu_pkg::ST_NOT_IMPL;
        end else if (r1_reg == fc_cal_reg) begin
            fe_code = mrtu_pkg::ST_CAL_OK;
            fe_data = r2_reg;
        end
    end

    assign rd_addr9  = 9'(idx_reg) + 9'd3;
    assign cmp_addr9 = 9'(idx_reg);
    assign cmp_mis   = mis_reg || (rdata_reg != req_reg[idx4]);

    assign st.command   = cmd_reg;
    assign st.rx_last   = rxl_reg;
    assign st.slot_free = slot_free;
    assign st.tx_last   = tx_last;
    assign st.tick_hit  = tick_hit;
    assign st.fend      = fe_kind;
    assign st.rd_zero   = (cnt_reg == 6'd0);
    assign st.rd_last   = (idx_reg + 6'd1 == cnt_reg);
    assign st.cmp_last  = (idx4 + 4'd1 == req_len_reg);

    // payload and memory
    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            mrtu_pkg::DP_LATCH: begin
                cmd_reg   <= s_tuser;
                dev_reg   <= s_tdata[7:0];
                raddr_reg <= s_tdata[23:8];
                cv_reg    <= s_tdata[39:24];
                point_reg <= s_tdata[47:40];
                dens_reg  <= s_tdata[79:48];
                rx_reg    <= s_tdata[87:80];
                rxl_reg   <= s_tlast;
            end
            mrtu_pkg::DP_RX_STORE: begin
                if (len_reg < LW'(RESP_BYTES)) begin
                    mem[len_reg[AW-1:0]] <= rx_reg;
                    prev2_reg <= prev1_reg;
                    prev1_reg <= rx_reg;
                    if (len9 == 9'd0) r0_reg <= rx_reg;
                    if (len9 == 9'd1) r1_reg <= rx_reg;
                    if (len9 == 9'd2) r2_reg <= rx_reg;
                end
            end
            mrtu_pkg::DP_FEND: begin
                cnt_reg <= cnt9[5:0];
            end
            mrtu_pkg::DP_RD_ISSUE:  rdata_reg <= mem[rd_addr9[AW-1:0]];
            mrtu_pkg::DP_CMP_ISSUE: rdata_reg <= mem[cmp_addr9[AW-1:0]];
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg     <= 16'd100;
            fc_read_reg   <= 8'd3;
            fc_write_reg  <= 8'd6;
            fc_multi_reg  <= 8'd16;
            fc_cal_reg    <= 8'd65;
            for (int i = 0; i < 9; i++) req_reg[i] <= 8'h00;
            req_len_reg   <= 4'd0;
            txcrc_reg     <= mrtu_pkg::CRC_INIT;
            idx_reg       <= 6'd0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            lcrc_reg      <= mrtu_pkg::CRC_INIT;
            mis_reg       <= 1'b0;
            tcount_reg    <= 16'd0;
            trun_reg      <= 1'b0;
            stat_code_reg <= 4'd0;
            stat_data_reg <= 8'h00;
            stat_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 2'd0;
            out_data_reg  <= 8'h00;
            out_status_reg <= 4'd0;
            out_last_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mrtu_pkg::CFG_TIMEOUT:  ticks_reg    <= cfg_data;
                    mrtu_pkg::CFG_FC_READ:  fc_read_reg  <= cfg_data[7:0];
                    mrtu_pkg::CFG_FC_WRITE: fc_write_reg <= cfg_data[7:0];
                    mrtu_pkg::CFG_FC_MULTI: fc_multi_reg <= cfg_data[7:0];
                    mrtu_pkg::CFG_FC_CAL:   fc_cal_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end

            if (m_tready && !push) out_valid_reg <= 1'b0;

            unique case (ctl.op)
                mrtu_pkg::DP_TX_INIT: begin
                    idx_reg   <= 6'd0;
                    txcrc_reg <= mrtu_pkg::CRC_INIT;
                    if (cmd_reg == mrtu_pkg::CMD_READ) begin
                        tcount_reg <= 16'd0;
                        trun_reg   <= 1'b1;
                    end
                end
                mrtu_pkg::DP_TX_BYTE: begin
                    req_reg[idx4] <= tx_byte;
                    if (idx4 < nb) txcrc_reg <= mrtu_pkg::crc_fold(txcrc_reg, tx_byte);
                    if (tx_last) req_len_reg <= nb + 4'd2;
                    idx_reg        <= idx_reg + 6'd1;
                    out_valid_reg  <= 1'b1;
                    out_kind_reg   <= mrtu_pkg::KIND_TX;
                    out_data_reg   <= tx_byte;
                    out_status_reg <= 4'd0;
                    out_last_reg   <= tx_last;
                end
                mrtu_pkg::DP_RX_STORE: begin
                    if (len_reg < LW'(RESP_BYTES)) begin
                        if (len9 >= 9'd2) lcrc_reg <= mrtu_pkg::crc_fold(lcrc_reg, prev2_reg);
                        len_reg <= LW'(len9 + 9'd1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                    if (rxl_reg) begin
                        trun_reg   <= 1'b0;
                        tcount_reg <= 16'd0;
                    end
                end
                mrtu_pkg::DP_TICK: begin
                    if (trun_reg) tcount_reg <= tick_hit ? 16'd0 : tcount_inc;
                    stat_code_reg <= mrtu_pkg::ST_NO_REPLY;
                    stat_data_reg <= 8'h00;
                    stat_last_reg <= 1'b1;
                end
                mrtu_pkg::DP_FEND: begin
                    stat_code_reg <= fe_code;
                    stat_data_reg <= fe_data;
                    stat_last_reg <= (fe_kind != mrtu_pkg::FE_READ) || (cnt9 == 9'd0);
                    idx_reg       <= 6'd0;
                    mis_reg       <= 1'b0;
                    len_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    lcrc_reg      <= mrtu_pkg::CRC_INIT;
                end
                mrtu_pkg::DP_STAT_PUSH: begin
                    out_valid_reg  <= 1'b1;
                    out_kind_reg   <= mrtu_pkg::KIND_STAT;
                    out_data_reg   <= stat_data_reg;
                    out_status_reg <= stat_code_reg;
                    out_last_reg   <= stat_last_reg;
                end
                mrtu_pkg::DP_RD_PUSH: begin
                    idx_reg        <= idx_reg + 6'd1;
                    out_valid_reg  <= 1'b1;
                    out_kind_reg   <= mrtu_pkg::KIND_DATA;
                    out_data_reg   <= rdata_reg;
                    out_status_reg <= 4'd0;
                    out_last_reg   <= (idx_reg + 6'd1 == cnt_reg);
                end
                mrtu_pkg::DP_CMP_CHECK: begin
                    idx_reg       <= idx_reg + 6'd1;
                    mis_reg       <= cmp_mis;
                    stat_code_reg <= cmp_mis ? mrtu_pkg::ST_WRITE_MIS : mrtu_pkg::ST_WRITE_OK;
                    stat_data_reg <= 8'h00;
                    stat_last_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_status_reg, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == mrtu_pkg::DP_TX_BYTE || ctl.op == mrtu_pkg::DP_STAT_PUSH ||
         ctl.op == mrtu_pkg::DP_RD_PUSH) |-> slot_free)
        else $error("result word pushed over a pending one");
    a_fend_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.op == mrtu_pkg::DP_FEND |=> (len_reg == '0 && !ovf_reg
                                         && lcrc_reg == mrtu_pkg::CRC_INIT))
        else $error("receive buffer not cleared at frame end");
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(RESP_BYTES))
        else $error("response length beyond buffer");
    a_req_len: assert property (@(posedge aclk) disable iff (!aresetn)
        req_len_reg == 4'd0 || req_len_reg == 4'd8 || req_len_reg == 4'd9)
        else $error("bad request length");

endmodule
`default_nettype wire

// ----- design/modbus_rtu_master_frame_engine_core.sv -----
// Request: the word is taken, then decoded, then one frame byte per cycle
//   (8 or 9 bytes, CRC computed byte-wise as they go out) while m_tready is high.
// Response byte / tick: taken, then stored or counted; a firing no-reply status is
//   pushed. Frame end: classified, status words pushed, each data byte or compared
//   request byte read, then pushed or checked (single registered buffer read port).
// Synchronous active-low reset; the receive buffer itself is not cleared.
`default_nettype none
module modbus_rtu_master_frame_engine_core #(
    parameter int RESP_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // slave_id, start_reg, count_or_value, point, density_bits, rx_byte
    input  wire logic [87:0] s_tdata,
    // command
    input  wire logic [2:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // data_byte, status, zero pad
    output logic [15:0]      m_tdata,
    // kind
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    mrtu_pkg::ctl_t     ctl;
    mrtu_pkg::dp_stat_t st;

    mrtu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .ctl      (ctl)
    );

    mrtu_datapath #(.RESP_BYTES(RESP_BYTES)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire
